/* sv/sfca_pkg.sv */
// sfca_pkg: shared constants, types and the byte-wise CRC-16/MODBUS update
// for the scope frame CRC appender. No dependencies.
package sfca_pkg;

    localparam int unsigned PAYLOAD_BYTES_DEF = 8;
    localparam int unsigned COUNT_W           = 6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // CRC trailer words still owed after the word in the output register
    typedef enum logic [1:0] {
        TRAIL_NONE,
        TRAIL_LO_HI,
        TRAIL_HI
    } trail_t;

    // Reflected CRC-16, one byte folded in (eight shift/xor steps)
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

/* sv/scope_frame_crc16_appender_core.sv */
// Top level of the scope frame CRC-16 appender: pass-through of payload
// words with the CRC-16/MODBUS trailer appended. Depends on sfca_pkg.

// Each payload word taken on the input channel comes out unchanged in the
// next cycle on the output channel. After the last payload word of a
// frame (PAYLOAD_BYTES words, 1..63) the block appends the CRC low byte
// and then the CRC high byte, with frame_end high on the high byte only.
// The CRC is CRC-16/MODBUS: reflected polynomial 0xA001, seed 0xFFFF, no
// final xor; it and the word count reseed after each frame. Throughput is
// one word per cycle while out_ready holds; a frame of N payload words
// occupies N+2 output words, since in_ready drops while the two CRC words
// are emitted from the single output register. The CRC update of one word
// is an eight-step shift/xor network between the input port and the CRC
// register.
module scope_frame_crc16_appender_core #(
    parameter int unsigned PAYLOAD_BYTES = sfca_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       frame_end
);
    import sfca_pkg::*;

    // Frame length as the 6-bit counter sees it; zero counts as one
    localparam logic [COUNT_W-1:0] LIMIT_RAW = COUNT_W'(PAYLOAD_BYTES);
    localparam logic [COUNT_W-1:0] LIMIT     =
        (LIMIT_RAW == '0) ? COUNT_W'(1) : LIMIT_RAW;

    // Frame state
    logic [15:0]        crc_reg,   crc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    // CRC captured at frame close, read out as the trailer
    logic [15:0]        hold_reg,  hold_next;
    // Output register
    logic               valid_reg, valid_next;
    logic [7:0]         byte_reg,  byte_next;
    logic               end_reg,   end_next;
    trail_t             trail_reg, trail_next;

    logic               advance;
    logic               in_take;
    logic [15:0]        crc_upd;
    logic [COUNT_W-1:0] count_inc;
    logic               closing;

    // Output slot can load a new word this cycle
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance && (trail_reg == TRAIL_NONE);
    assign in_take  = in_valid && in_ready;

    assign crc_upd   = crc16_byte(crc_reg, data_byte);
    assign count_inc = count_reg + COUNT_W'(1);
    assign closing   = (count_inc >= LIMIT);

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        hold_next  = hold_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        trail_next = trail_reg;

        if (advance)
        begin
            case (trail_reg)
                TRAIL_LO_HI:
                begin
                    valid_next = 1'b1;
                    byte_next  = hold_reg[7:0];
                    end_next   = 1'b0;
                    trail_next = TRAIL_HI;
                end
                TRAIL_HI:
                begin
                    valid_next = 1'b1;
                    byte_next  = hold_reg[15:8];
                    end_next   = 1'b1;
                    trail_next = TRAIL_NONE;
                end
                default:
                begin
                    valid_next = in_take;
                    byte_next  = data_byte;
                    end_next   = 1'b0;
                    if (in_take)
                    begin
                        if (closing)
                        begin
                            // Close the frame: park the CRC, reseed
                            hold_next  = crc_upd;
                            crc_next   = CRC_INIT;
                            count_next = '0;
                            trail_next = TRAIL_LO_HI;
                        end
                        else
                        begin
                            crc_next   = crc_upd;
                            count_next = count_inc;
                            trail_next = TRAIL_NONE;
                        end
                    end
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            valid_reg <= 1'b0;
            trail_reg <= TRAIL_NONE;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            trail_reg <= trail_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign frame_end = end_reg;

endmodule

/* sv/sfca_checker.sv */
// sfca_checker: port-level assertions for scope_frame_crc16_appender_core,
// attached by the bind below. No package dependency.
module sfca_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] data_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       frame_end
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end))
        else $error("output word changed while stalled");

    // Input is only taken when the output slot can move
    a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_ready))
        else $error("in_ready high with output blocked");

    // An accepted input word shows up the next cycle as a payload word
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid && !frame_end && out_byte == $past(data_byte))
        else $error("accepted word not passed through");

    // Two frame closes never come back to back
    a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && frame_end |=> !(out_valid && frame_end))
        else $error("frame_end on consecutive words");

endmodule

bind scope_frame_crc16_appender_core sfca_checker u_sfca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_end (frame_end)
);

/* bench/frame_crc_monitor.sv */
// frame_crc_monitor: watches both channels of the scope frame CRC appender,
// predicts every outgoing word and compares it. Depends on sfca_pkg.
`timescale 1ns / 100ps

module frame_crc_monitor #(
    parameter int unsigned FRAME_LEN = sfca_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       frame_end,
    output int         mismatches,
    output int         pending
);

    import sfca_pkg::*;

    // byte count wraps in 6 bits; 0 or 1 both mean a one-byte frame
    localparam logic [5:0] LEN_WRAPPED = FRAME_LEN[5:0];
    localparam logic [5:0] CLOSE_AT    = (LEN_WRAPPED == 6'd0) ? 6'd1 : LEN_WRAPPED;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } tx_word_t;

    tx_word_t    expected_tx_words[$];
    logic [15:0] frame_crc;
    logic [5:0]  frame_count;
    int          err_count;

    // LSB-first serial form of the reflected CRC-16 update
    function automatic logic [15:0] crc16_fold_byte(input logic [15:0] crc,
                                                    input logic [7:0]  b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int k = 0; k < 8; k++) begin
            fb  = acc[0] ^ b[k];
            acc = acc >> 1;
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tx_word_t    got;
        tx_word_t    want;
        logic [5:0]  next_count;
        if (!rst_n)
        begin
            frame_crc   = CRC_INIT;
            frame_count = '0;
            err_count   = 0;
            expected_tx_words.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                frame_crc  = crc16_fold_byte(frame_crc, data_byte);
                next_count = frame_count + 6'd1;
                expected_tx_words.push_back('{value: data_byte, last: 1'b0});
                if (next_count >= CLOSE_AT)
                begin
                    expected_tx_words.push_back('{value: frame_crc[7:0], last: 1'b0});
                    expected_tx_words.push_back('{value: frame_crc[15:8], last: 1'b1});
                    frame_crc   = CRC_INIT;
                    frame_count = '0;
                end
                else
                    frame_count = next_count;
            end

            if (out_valid && out_ready)
            begin
                got = '{value: out_byte, last: frame_end};
                if (expected_tx_words.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected word: out_byte=%02h frame_end=%0b",
                             $time, got.value, got.last);
                end
                else
                begin
                    want = expected_tx_words.pop_front();
                    if (got.value !== want.value)
                    begin
                        err_count++;
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.value, got.value);
                    end
                    if (got.last !== want.last)
                    begin
                        err_count++;
                        $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                                 $time, want.last, got.last);
                    end
                end
            end

            mismatches <= err_count;
            pending    <= expected_tx_words.size();
        end
    end

endmodule

/* bench/tb_top.sv */
// tb_top: stimulus and verdict for scope_frame_crc16_appender_core.
// Depends on sfca_pkg, the core and bench/frame_crc_monitor.sv.
`timescale 1ns / 100ps

module tb_top;

    import sfca_pkg::*;

    localparam int RAND_WORDS_PER_PHASE = 79;
    localparam int DRAIN_LIMIT          = 20000;  // cycles to wait for the queue to empty
    localparam int TAIL_CYCLES          = 10;     // settle time after the last result

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       frame_end;

    int mismatches;
    int pending;

    // per-cycle idle odds, in percent, for each side
    int send_idle_pct;
    int recv_idle_pct;

    scope_frame_crc16_appender_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

    // the monitor keeps its own CRC and expected-word queue
    frame_crc_monitor #(
        .FRAME_LEN (PAYLOAD_BYTES_DEF)
    ) u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .frame_end  (frame_end),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: ready is redrawn every cycle from the current stall odds.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Hard stop. The slowest legal run (every word stalled for a long
    // stretch on both sides) is far below this.
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Offer one payload word. Idle cycles before it are drawn from the
    // sender odds; valid is held until the word is taken.
    task automatic send_payload_word(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and hold off until the monitor has seen every owed word.
    // The first edge lets the monitor count the word just accepted.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Random payload, skewed toward the all-zero and all-one bytes.
    function automatic logic [7:0] pick_payload_byte();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0)
            return 8'h00;
        else if (sel == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic random_phase(input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < RAND_WORDS_PER_PHASE; n++)
            send_payload_word(pick_payload_byte());
    endtask

    initial
    begin
        int wait_cycles;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        send_idle_pct = 21;
        recv_idle_pct = 66;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: all zeros, all ones, then alternating bit
        // patterns so each data bit toggles. Every eighth word closes a
        // frame and must be followed by the CRC low and high bytes.
        for (int n = 0; n < PAYLOAD_BYTES_DEF; n++)
            send_payload_word(8'h00);
        for (int n = 0; n < PAYLOAD_BYTES_DEF; n++)
            send_payload_word(8'hFF);
        for (int n = 0; n < PAYLOAD_BYTES_DEF; n++)
            send_payload_word(n[0] ? 8'hAA : 8'h55);

        // let the trailer drain completely before random traffic
        hold_until_drained();

        // sender idles less than the receiver stalls
        random_phase(21, 66);
        hold_until_drained();

        // then the other way round
        random_phase(66, 21);
        hold_until_drained();

        // back to back on both sides
        random_phase(0, 0);
        in_valid <= 1'b0;

        // Drain: the last frame may be partial, which still owes one word
        // per accepted byte.
        wait_cycles = 0;
        do
        begin
            @(posedge clk);
            wait_cycles++;
        end
        while (pending != 0 && wait_cycles < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
